@@ rtl/hht_pkg.sv @@
// Shared types and codes for the HTTP header tokenizer.
package hht_pkg;

    localparam logic [2:0] KIND_NEWLINE = 3'd0;
    localparam logic [2:0] KIND_NAME    = 3'd1;
    localparam logic [2:0] KIND_COLON   = 3'd2;
    localparam logic [2:0] KIND_VALUE   = 3'd3;
    localparam logic [2:0] KIND_CRWAIT  = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    localparam logic [3:0] ST_LINE     = 4'd0;
    localparam logic [3:0] ST_NAME     = 4'd1;
    localparam logic [3:0] ST_SEP      = 4'd2;
    localparam logic [3:0] ST_VALUE    = 4'd3;
    localparam logic [3:0] ST_END      = 4'd4;
    localparam logic [3:0] ST_ERR      = 4'd5;
    localparam logic [3:0] ST_CR_NAME  = 4'd6;
    localparam logic [3:0] ST_CR_VALUE = 4'd7;
    localparam logic [3:0] ST_CR_LINE  = 4'd8;
    localparam logic [3:0] ST_OWS      = 4'd9;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [2:0] kind;
        logic       has_data;
        logic [7:0] data;
    } event_t;

    typedef struct packed {
        event_t ev0;
        event_t ev1;
        logic   two;
    } entry_t;

    function automatic event_t make_event(input logic [2:0] kind, input logic has,
                                          input logic [7:0] data);
        event_t ev;
        ev.kind     = kind;
        ev.has_data = has;
        ev.data     = has ? data : 8'd0;
        return ev;
    endfunction

endpackage

@@ rtl/hht_front.sv @@
// Tokenizer state machine: accepts header bytes and classifies them into event pairs.
module hht_front
    import hht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_valid,
    output logic       in_ready,
    output entry_t     push_data,
    output logic       push_valid,
    input  logic       push_ready
);

    logic [3:0] state_reg;
    logic [3:0] state_next;
    entry_t     entry;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_data  = entry;

    always_comb
    begin
        entry.ev0  = make_event(KIND_ERROR, 1'b0, 8'd0);
        entry.ev1  = make_event(KIND_ERROR, 1'b0, 8'd0);
        entry.two  = 1'b0;
        state_next = ST_ERR;
        case (state_reg)
            ST_LINE:
            begin
                if (in_byte == CH_COLON)
                begin
                    state_next = ST_ERR;
                end
                else if (in_byte == CH_CR)
                begin
                    state_next = ST_CR_LINE;
                    entry.ev0  = make_event(KIND_CRWAIT, 1'b0, 8'd0);
                end
                else
                begin
                    state_next = ST_NAME;
                    entry.ev0  = make_event(KIND_NAME, 1'b1, in_byte);
                end
            end
            ST_NAME:
            begin
                if (in_byte == CH_COLON)
                begin
                    state_next = ST_SEP;
                    entry.ev0  = make_event(KIND_COLON, 1'b0, 8'd0);
                end
                else if (in_byte == CH_CR)
                begin
                    state_next = ST_CR_NAME;
                    entry.ev0  = make_event(KIND_CRWAIT, 1'b0, 8'd0);
                end
                else
                begin
                    state_next = ST_NAME;
                    entry.ev0  = make_event(KIND_NAME, 1'b1, in_byte);
                end
            end
            ST_SEP, ST_OWS:
            begin
                if (in_byte == CH_CR)
                begin
                    state_next = ST_CR_VALUE;
                    entry.ev0  = make_event(KIND_VALUE, 1'b0, 8'd0);
                end
                else if (in_byte == CH_SP)
                begin
                    state_next = ST_OWS;
                    entry.ev0  = make_event(KIND_VALUE, 1'b0, 8'd0);
                end
                else
                begin
                    state_next = ST_VALUE;
                    entry.ev0  = make_event(KIND_VALUE, 1'b1, in_byte);
                end
            end
            ST_VALUE:
            begin
                if (in_byte == CH_CR)
                begin
                    state_next = ST_CR_VALUE;
                    entry.ev0  = make_event(KIND_VALUE, 1'b0, 8'd0);
                end
                else
                begin
                    state_next = ST_VALUE;
                    entry.ev0  = make_event(KIND_VALUE, 1'b1, in_byte);
                end
            end
            ST_CR_NAME:
            begin
                if (in_byte == CH_CR)
                begin
                    state_next = ST_CR_NAME;
                    entry.ev0  = make_event(KIND_NAME, 1'b1, CH_CR);
                end
                else if (in_byte == CH_LF)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    state_next = ST_NAME;
                    entry.ev0  = make_event(KIND_NAME, 1'b1, CH_CR);
                    entry.ev1  = make_event(KIND_VALUE, 1'b1, in_byte);
                    entry.two  = 1'b1;
                end
            end
            ST_CR_VALUE:
            begin
                if (in_byte == CH_CR)
                begin
                    state_next = ST_CR_VALUE;
                    entry.ev0  = make_event(KIND_VALUE, 1'b1, CH_CR);
                end
                else if (in_byte == CH_LF)
                begin
                    state_next = ST_LINE;
                    entry.ev0  = make_event(KIND_NEWLINE, 1'b1, CH_LF);
                end
                else
                begin
                    state_next = ST_VALUE;
                    entry.ev0  = make_event(KIND_VALUE, 1'b1, CH_CR);
                    entry.ev1  = make_event(KIND_VALUE, 1'b1, in_byte);
                    entry.two  = 1'b1;
                end
            end
            ST_CR_LINE:
            begin
                if (in_byte == CH_CR)
                begin
                    state_next = ST_CR_NAME;
                    entry.ev0  = make_event(KIND_VALUE, 1'b1, CH_CR);
                end
                else if (in_byte == CH_LF)
                begin
                    state_next = ST_END;
                    entry.ev0  = make_event(KIND_END, 1'b0, 8'd0);
                end
                else
                begin
                    state_next = ST_VALUE;
                    entry.ev0  = make_event(KIND_VALUE, 1'b1, CH_CR);
                    entry.ev1  = make_event(KIND_VALUE, 1'b1, in_byte);
                    entry.two  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LINE;
        end
        else if (in_valid && push_ready)
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/hht_queue.sv @@
// Short FIFO of classified event pairs between the tokenizer and the output stage.
module hht_queue
    import hht_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  entry_t push_data,
    input  logic   push_valid,
    output logic   push_ready,
    output entry_t pop_data,
    output logic   pop_valid,
    input  logic   pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/hht_back.sv @@
// Output stage: holds one event pair and emits its events one word at a time.
module hht_back
    import hht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     pop_data,
    input  logic       pop_valid,
    output logic       pop_ready,
    output logic [2:0] event_kind,
    output logic       has_data,
    output logic [7:0] data_byte,
    output logic       last_event,
    output logic       out_valid,
    input  logic       out_ready
);

    entry_t hold_reg;
    logic   hold_valid_reg;
    logic   phase_reg;
    event_t cur;
    logic   is_last;

    assign cur        = phase_reg ? hold_reg.ev1 : hold_reg.ev0;
    assign is_last    = phase_reg || !hold_reg.two;
    assign event_kind = cur.kind;
    assign has_data   = cur.has_data;
    assign data_byte  = cur.data;
    assign last_event = is_last;
    assign out_valid  = hold_valid_reg;
    assign pop_ready  = !hold_valid_reg || (out_ready && is_last);

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            hold_reg <= pop_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else if (pop_ready)
        begin
            hold_valid_reg <= pop_valid;
            phase_reg      <= 1'b0;
        end
        else if (out_ready)
        begin
            // advance to the second event of the pair
            phase_reg <= 1'b1;
        end
    end

endmodule

@@ rtl/http_header_tokenizer.sv @@
// Top level of the HTTP header tokenizer.
//
// Input channel: in_byte with in_valid / in_ready, one header byte per word.
// Output channel: event_kind, has_data, data_byte, last_event with
// out_valid / out_ready; each input byte yields one or two event words, the
// last one flagged by last_event.
// A byte is taken every cycle while the event queue (QUEUE_DEPTH entries)
// has room; the tokenizer state register and one byte compare set this rate.
// An accepted byte's events are written into the queue and then loaded
// into the output stage register before they appear on the output.
// The output stage sends one event word per cycle while out_ready is high;
// two-event bytes hold it for both words; the queue absorbs short bursts.
// When the receiver stalls, the output word holds and the queue fills; once
// it is full, in_ready drops until words are taken again.
// Reset empties the queue and output stage and returns the tokenizer to
// the line start state.
module http_header_tokenizer
    import hht_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [2:0] event_kind,
    output logic       has_data,
    output logic [7:0] data_byte,
    output logic       last_event,
    output logic       out_valid,
    input  logic       out_ready
);

    entry_t push_data;
    logic   push_valid;
    logic   push_ready;
    entry_t pop_data;
    logic   pop_valid;
    logic   pop_ready;

    hht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    hht_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    hht_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .event_kind (event_kind),
        .has_data   (has_data),
        .data_byte  (data_byte),
        .last_event (last_event),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

@@ bench/http_header_tokenizer_check.sv @@
`timescale 1ns / 1ps
// Event predictor and scoreboard for the HTTP header tokenizer channels.
module http_header_tokenizer_check
    import hht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] event_kind,
    input  logic       has_data,
    input  logic [7:0] data_byte,
    input  logic       last_event,
    input  logic       out_valid,
    input  logic       out_ready,
    output int         mismatch_count,
    output int         events_pending
);

    typedef struct packed {
        logic [2:0] kind;
        logic       has_data;
        logic [7:0] data;
        logic       last;
    } token_event_t;

    token_event_t expected_events[$];
    logic [3:0]   tok_state = ST_LINE;

    function automatic void queue_event(input logic [2:0] kind, input logic has,
                                        input logic [7:0] data, input logic last);
        token_event_t ev;
        ev.kind     = kind;
        ev.has_data = has;
        ev.data     = has ? data : 8'd0;
        ev.last     = last;
        expected_events.push_back(ev);
    endfunction

    task automatic tokenize_byte(input logic [7:0] c);
        logic [3:0] next_state;
        next_state = ST_ERR;
        case (tok_state)
            ST_LINE:
                if (c == CH_COLON)
                begin
                    next_state = ST_ERR;
                    queue_event(KIND_ERROR, 1'b0, 8'd0, 1'b1);
                end
                else if (c == CH_CR)
                begin
                    next_state = ST_CR_LINE;
                    queue_event(KIND_CRWAIT, 1'b0, 8'd0, 1'b1);
                end
                else
                begin
                    next_state = ST_NAME;
                    queue_event(KIND_NAME, 1'b1, c, 1'b1);
                end
            ST_NAME:
                if (c == CH_COLON)
                begin
                    next_state = ST_SEP;
                    queue_event(KIND_COLON, 1'b0, 8'd0, 1'b1);
                end
                else if (c == CH_CR)
                begin
                    next_state = ST_CR_NAME;
                    queue_event(KIND_CRWAIT, 1'b0, 8'd0, 1'b1);
                end
                else
                begin
                    next_state = ST_NAME;
                    queue_event(KIND_NAME, 1'b1, c, 1'b1);
                end
            ST_SEP, ST_OWS:
                if (c == CH_CR)
                begin
                    next_state = ST_CR_VALUE;
                    queue_event(KIND_VALUE, 1'b0, 8'd0, 1'b1);
                end
                else if (c == CH_SP)
                begin
                    next_state = ST_OWS;
                    queue_event(KIND_VALUE, 1'b0, 8'd0, 1'b1);
                end
                else
                begin
                    next_state = ST_VALUE;
                    queue_event(KIND_VALUE, 1'b1, c, 1'b1);
                end
            ST_VALUE:
                if (c == CH_CR)
                begin
                    next_state = ST_CR_VALUE;
                    queue_event(KIND_VALUE, 1'b0, 8'd0, 1'b1);
                end
                else
                begin
                    next_state = ST_VALUE;
                    queue_event(KIND_VALUE, 1'b1, c, 1'b1);
                end
            ST_CR_NAME:
                if (c == CH_CR)
                begin
                    next_state = ST_CR_NAME;
                    queue_event(KIND_NAME, 1'b1, CH_CR, 1'b1);
                end
                else if (c == CH_LF)
                begin
                    next_state = ST_ERR;
                    queue_event(KIND_ERROR, 1'b0, 8'd0, 1'b1);
                end
                else
                begin
                    next_state = ST_NAME;
                    queue_event(KIND_NAME, 1'b1, CH_CR, 1'b0);
                    queue_event(KIND_VALUE, 1'b1, c, 1'b1);
                end
            ST_CR_VALUE:
                if (c == CH_CR)
                begin
                    next_state = ST_CR_VALUE;
                    queue_event(KIND_VALUE, 1'b1, CH_CR, 1'b1);
                end
                else if (c == CH_LF)
                begin
                    next_state = ST_LINE;
                    queue_event(KIND_NEWLINE, 1'b1, CH_LF, 1'b1);
                end
                else
                begin
                    next_state = ST_VALUE;
                    queue_event(KIND_VALUE, 1'b1, CH_CR, 1'b0);
                    queue_event(KIND_VALUE, 1'b1, c, 1'b1);
                end
            ST_CR_LINE:
                if (c == CH_CR)
                begin
                    next_state = ST_CR_NAME;
                    queue_event(KIND_VALUE, 1'b1, CH_CR, 1'b1);
                end
                else if (c == CH_LF)
                begin
                    next_state = ST_END;
                    queue_event(KIND_END, 1'b0, 8'd0, 1'b1);
                end
                else
                begin
                    next_state = ST_VALUE;
                    queue_event(KIND_VALUE, 1'b1, CH_CR, 1'b0);
                    queue_event(KIND_VALUE, 1'b1, c, 1'b1);
                end
            default:
                begin
                    next_state = ST_ERR;
                    queue_event(KIND_ERROR, 1'b0, 8'd0, 1'b1);
                end
        endcase
        tok_state = next_state;
    endtask

    always @(posedge clk)
    begin : watch
        token_event_t want;
        if (!rst_n)
        begin
            tok_state = ST_LINE;
            expected_events.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                tokenize_byte(in_byte);
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("event word with nothing expected: kind %0d data %0h",
                           event_kind, data_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_kind !== want.kind)
                    begin
                        $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                        mismatch_count++;
                    end
                    if (has_data !== want.has_data)
                    begin
                        $error("has_data: expected %0d, got %0d", want.has_data, has_data);
                        mismatch_count++;
                    end
                    if (data_byte !== want.data)
                    begin
                        $error("data_byte: expected %0h, got %0h", want.data, data_byte);
                        mismatch_count++;
                    end
                    if (last_event !== want.last)
                    begin
                        $error("last_event: expected %0d, got %0d", want.last, last_event);
                        mismatch_count++;
                    end
                end
            end
        end
        events_pending <= expected_events.size();
    end

endmodule

@@ bench/http_header_tokenizer_test.sv @@
`timescale 1ns / 1ps
// Top-level testbench: header byte stimulus, receiver stalls and verdict.
module http_header_tokenizer_test
    import hht_pkg::*;
();

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic [7:0] in_byte   = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [2:0] event_kind;
    logic       has_data;
    logic [7:0] data_byte;
    logic       last_event;
    logic       out_valid;
    logic       out_ready = 1'b0;

    int mismatch_count;
    int events_pending;

    logic [7:0] header_bytes[$];
    logic [7:0] opening_bytes [31] = '{
        8'h00, 8'hFF, CH_COLON, CH_SP, CH_SP, CH_CR, CH_CR, 8'hFF, 8'h00, CH_CR, CH_LF,
        CH_LF, CH_CR, CH_CR, 8'h41, CH_COLON, CH_CR, 8'h7A, CH_CR, CH_LF,
        CH_CR, CH_CR, CH_COLON, CH_COLON, 8'h42, CH_CR, CH_LF,
        CH_CR, 8'h80, CH_CR, CH_LF
    };

    int         stall_left = 0;
    logic [1:0] stall_mode = 2'd0;

    http_header_tokenizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .event_kind (event_kind),
        .has_data   (has_data),
        .data_byte  (data_byte),
        .last_event (last_event),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    http_header_tokenizer_check event_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_byte        (in_byte),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .event_kind     (event_kind),
        .has_data       (has_data),
        .data_byte      (data_byte),
        .last_event     (last_event),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 300);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= stall_left[2];
        endcase
    end

    function automatic logic [7:0] rand_byte_not(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] pick;
        pick = 8'($urandom_range(0, 255));
        while (pick == a || pick == b)
            pick = 8'($urandom_range(0, 255));
        return pick;
    endfunction

    // hold a CR, then break the line end with a byte other than LF
    task automatic add_cr_hold();
        header_bytes.push_back(CH_CR);
        repeat ($urandom_range(0, 2))
            header_bytes.push_back(CH_CR);
        header_bytes.push_back(rand_byte_not(CH_CR, CH_LF));
    endtask

    task automatic add_value_tail();
        repeat ($urandom_range(0, 10))
        begin
            header_bytes.push_back(rand_byte_not(CH_CR, CH_CR));
            if ($urandom_range(0, 9) == 0)
                add_cr_hold();
        end
        header_bytes.push_back(CH_CR);
        header_bytes.push_back(CH_LF);
    endtask

    task automatic add_field_line();
        repeat ($urandom_range(1, 6))
        begin
            header_bytes.push_back(rand_byte_not(CH_COLON, CH_CR));
            if ($urandom_range(0, 9) == 0)
                add_cr_hold();
        end
        header_bytes.push_back(CH_COLON);
        repeat ($urandom_range(0, 3))
            header_bytes.push_back(CH_SP);
        add_value_tail();
    endtask

    task automatic add_odd_line();
        header_bytes.push_back(CH_CR);
        if ($urandom_range(0, 1) == 0)
        begin
            add_cr_hold();
            header_bytes.push_back(CH_COLON);
        end
        else
            header_bytes.push_back(rand_byte_not(CH_CR, CH_LF));
        add_value_tail();
    endtask

    task automatic send_header_bytes();
        int burst_left;
        burst_left = $urandom_range(1, 40);
        foreach (header_bytes[idx])
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 40);
            end
            in_valid <= 1'b1;
            in_byte  <= header_bytes[idx];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            burst_left--;
        end
        in_valid <= 1'b0;
        header_bytes.delete();
    endtask

    task automatic wait_events_drained();
        @(posedge clk);
        while (events_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_bytes[i])
            header_bytes.push_back(opening_bytes[i]);
        send_header_bytes();
        wait_events_drained();

        while (header_bytes.size() < 1250)
        begin
            if ($urandom_range(0, 6) == 0)
                add_odd_line();
            else
                add_field_line();
        end
        send_header_bytes();
        wait_events_drained();

        // lock the tokenizer: colon at line start, LF after CR in a name, or blank line
        case ($urandom_range(0, 2))
            0: header_bytes.push_back(CH_COLON);
            1:
            begin
                header_bytes.push_back(rand_byte_not(CH_COLON, CH_CR));
                header_bytes.push_back(CH_CR);
                header_bytes.push_back(CH_LF);
            end
            default:
            begin
                header_bytes.push_back(CH_CR);
                header_bytes.push_back(CH_LF);
            end
        endcase
        repeat (4)
            header_bytes.push_back(8'($urandom_range(0, 255)));
        header_bytes.push_back(CH_COLON);
        send_header_bytes();
        wait_events_drained();
        repeat (20)
            @(posedge clk);

        if (mismatch_count == 0 && events_pending == 0)
            $display("http_header_tokenizer test passed");
        else
            $display("http_header_tokenizer test failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("http_header_tokenizer test failed");
        $finish;
    end

endmodule
